// ===== sv/scale_weight_frame_stabilizer_defines.svh =====
// Assertion macros shared by the scale weight frame stabilizer RTL.
`ifndef SCALE_WEIGHT_FRAME_STABILIZER_DEFINES_SVH
`define SCALE_WEIGHT_FRAME_STABILIZER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on clk, disabled during rst.
`define SWFS_ASSERT_NOW(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);
// Next-cycle implication, checked on clk, disabled during rst.
`define SWFS_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);
`else
`define SWFS_ASSERT_NOW(lbl, cond, expr, msg)
`define SWFS_ASSERT_NEXT(lbl, cond, expr, msg)
`endif

`endif

// ===== sv/swfs_pkg.sv =====
// Shared types and constants for the scale weight frame stabilizer.
`timescale 1ns / 1ps
`default_nettype none
package swfs_pkg;

  // Result kinds
  localparam logic [2:0] KIND_LIVE    = 3'd0;
  localparam logic [2:0] KIND_FINAL   = 3'd1;
  localparam logic [2:0] KIND_READY   = 3'd2;
  localparam logic [2:0] KIND_READING = 3'd3;
  localparam logic [2:0] KIND_IDLE    = 3'd4;

  // Register indexes
  localparam logic [2:0] CFG_MIN_LOAD      = 3'd0;
  localparam logic [2:0] CFG_TOLERANCE     = 3'd1;
  localparam logic [2:0] CFG_STEADY_FRAMES = 3'd2;
  localparam logic [2:0] CFG_LOADED_WINDOW = 3'd3;
  localparam logic [2:0] CFG_REARM_DELAY   = 3'd4;
  localparam logic [2:0] CFG_IDLE_LIMIT    = 3'd5;

  // Register reset values
  localparam logic [15:0] MIN_LOAD_RESET      = 16'd300;
  localparam logic [15:0] TOLERANCE_RESET     = 16'd30;
  localparam logic [3:0]  STEADY_FRAMES_RESET = 4'd5;
  localparam logic [17:0] LOADED_WINDOW_RESET = 18'd1500;
  localparam logic [17:0] REARM_DELAY_RESET   = 18'd3000;
  localparam logic [17:0] IDLE_LIMIT_RESET    = 18'd180000;

  // Weight value that marks a missing final weight
  localparam logic [16:0] WEIGHT_ABSENT = 17'h1FFFF;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [15:0]        weight_centikg;
    logic               recorded;
    logic signed [15:0] impedance;
  } result_t;

  typedef struct packed {
    logic        we;
    logic [2:0]  index;
    logic [17:0] data;
  } cfg_t;

  // Frame end events from the parser
  typedef struct packed {
    logic               live_end;
    logic               final_end;
    logic [15:0]        raw_weight;
    logic [16:0]        final_weight;
    logic signed [15:0] final_impedance;
  } frame_info_t;

endpackage
`default_nettype wire

// ===== sv/scale_weight_frame_stabilizer.sv =====
// Top level of the scale weight frame stabilizer.
//
// Input words (item) are either one frame byte with a last-byte mark
// (op = 0) or a one millisecond tick (op = 1), taken on item_valid and
// item_ready. The last byte of a qualifying frame, and some ticks, give
// one result word (result) on result_valid and result_ready: live weight,
// final record, ready and reading status, idle release.
// A taken word's result is registered in the output register, or in the
// skid entry on a stall. One word per cycle while item_ready is high, set
// by the single state update from frame and stability registers to output.
// Configuration: cfg_we, cfg_index and cfg_data, one register per cycle;
// the user writes only while the block is idle; no logic here enforces it.
// When the receiver stalls, one more result is held in a skid entry and
// item_ready drops until the output register drains.
// Reset (rst, synchronous): registers take their default values, all
// frame, stability and timer state clears, and both channels are empty.
`timescale 1ns / 1ps
`default_nettype none
`include "scale_weight_frame_stabilizer_defines.svh"
module scale_weight_frame_stabilizer (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  swfs_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output swfs_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [17:0]       cfg_data
);

  logic                  accept;
  logic                  take;
  logic                  tick;
  swfs_pkg::cfg_t        cfg;
  swfs_pkg::frame_info_t info;
  logic                  res_valid;
  swfs_pkg::result_t     res;

  assign accept    = item_valid && item_ready;
  assign take      = accept && !item.op;
  assign tick      = accept && item.op;
  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  swfs_frame_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (item.data_byte),
    .last_byte (item.last_byte),
    .info      (info)
  );

  swfs_stabilizer u_stab (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .tick      (tick),
    .info      (info),
    .res_valid (res_valid),
    .res       (res)
  );

  swfs_out_buffer u_out (
    .clk          (clk),
    .rst          (rst),
    .push         (accept && res_valid),
    .push_data    (res),
    .space        (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // A full skid entry means the output register is full too
  `SWFS_ASSERT_NOW(a_skid_behind_out, !item_ready, result_valid, "skid full with empty output")
  // Status words carry no weight, record or impedance
  `SWFS_ASSERT_NOW(a_status_clean,
    result_valid && (result.kind == swfs_pkg::KIND_READY ||
                     result.kind == swfs_pkg::KIND_READING ||
                     result.kind == swfs_pkg::KIND_IDLE),
    result.weight_centikg == 16'd0 && !result.recorded && result.impedance == 16'sd0,
    "status word with payload")
  // A mid-frame byte never makes a result
  `SWFS_ASSERT_NEXT(a_mid_frame_quiet,
    accept && !item.op && !item.last_byte && !result_valid,
    !result_valid, "result from a mid-frame byte")

endmodule
`default_nettype wire

// ===== sv/swfs_frame_parser.sv =====
// Frame byte parser: frame type, live weight bytes and comma text fields.
`timescale 1ns / 1ps
`default_nettype none
module swfs_frame_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output swfs_pkg::frame_info_t info
);

  localparam logic [7:0] TYPE_LIVE  = 8'h19;
  localparam logic [7:0] TYPE_FIN_A = 8'h22;
  localparam logic [7:0] TYPE_FIN_B = 8'h2b;
  localparam logic [7:0] TYPE_FIN_C = 8'h23;
  localparam logic [7:0] TEXT_MARK  = 8'ha0;
  localparam logic [7:0] TEXT_MAX   = 8'd159;
  localparam logic [7:0] IDX_WLO    = 8'd23;
  localparam logic [7:0] IDX_WHI    = 8'd24;
  localparam logic [7:0] LIVE_LAST  = 8'd24;
  localparam logic [7:0] FIN_LAST   = 8'd13;
  localparam logic [7:0] IDX_MAX    = 8'd255;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [2:0] TOK_WEIGHT = 3'd2;
  localparam logic [2:0] TOK_IMP    = 3'd3;
  localparam logic [2:0] TOK_MAX    = 3'd7;
  localparam logic [1:0] PH_SPACE   = 2'd0;
  localparam logic [1:0] PH_DIGITS  = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;
  localparam logic [16:0] ACC_MAX   = 17'h1FFFF;

  typedef struct packed {
    logic       seen_a0;
    logic       stopped;
    logic       in_token;
    logic [2:0] token_idx;
    logic [1:0] phase;
    logic       negative;
    logic [7:0] text_len;
  } csv_t;

  typedef struct packed {
    csv_t               cs;
    logic [16:0]        fw;
    logic signed [15:0] fi;
  } tok_t;

  logic [7:0]         byte_index;
  logic [7:0]         frame_type;
  logic [15:0]        raw_weight;
  csv_t               csv_parse_state;
  logic [16:0]        number_accum;
  logic [16:0]        final_weight;
  logic signed [15:0] final_impedance;

  logic [7:0]         frame_type_next;
  logic [15:0]        raw_weight_next;
  csv_t               csv_next;
  logic [16:0]        accum_next;
  logic [16:0]        final_weight_next;
  logic signed [15:0] final_impedance_next;
  tok_t               end_tok;

  // Close one token: store weight or impedance field, advance token count
  function automatic tok_t finish_token(input csv_t c, input logic [16:0] acc,
                                        input logic [16:0] fw_in,
                                        input logic signed [15:0] fi_in);
    tok_t t;
    t.cs = c;
    t.fw = fw_in;
    t.fi = fi_in;
    if (c.token_idx == TOK_WEIGHT) begin
      if (c.negative && acc != 17'd0) begin
        t.fw = swfs_pkg::WEIGHT_ABSENT;
      end else begin
        t.fw = (acc > 17'h0FFFF) ? 17'h0FFFF : acc;
      end
    end else if (c.token_idx == TOK_IMP) begin
      if (c.negative) begin
        t.fi = (acc > 17'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, acc}));
      end else begin
        t.fi = (acc > 17'd32767) ? 16'sd32767 : $signed(acc[15:0]);
      end
    end
    if (c.token_idx < TOK_MAX) begin
      t.cs.token_idx = c.token_idx + 3'd1;
    end
    t.cs.in_token = 1'b0;
    return t;
  endfunction

  // Apply one byte to the frame state
  always_comb begin
    logic [20:0] wide;
    tok_t        t;
    wide = '0;
    t = '0;
    if (byte_index == 8'd0) begin
      frame_type_next      = data_byte;
      raw_weight_next      = '0;
      csv_next             = '0;
      accum_next           = '0;
      final_weight_next    = swfs_pkg::WEIGHT_ABSENT;
      final_impedance_next = '0;
    end else begin
      frame_type_next      = frame_type;
      raw_weight_next      = raw_weight;
      csv_next             = csv_parse_state;
      accum_next           = number_accum;
      final_weight_next    = final_weight;
      final_impedance_next = final_impedance;
    end

    // Little-endian live weight
    if (byte_index == IDX_WLO) begin
      raw_weight_next[7:0] = data_byte;
    end else if (byte_index == IDX_WHI) begin
      raw_weight_next[15:8] = data_byte;
    end

    // Comma text after the first marker byte
    if (!csv_next.seen_a0) begin
      if (data_byte == TEXT_MARK) begin
        csv_next.seen_a0 = 1'b1;
      end
    end else if (!csv_next.stopped) begin
      if (data_byte == 8'd0 || csv_next.text_len >= TEXT_MAX) begin
        csv_next.stopped = 1'b1;
      end else begin
        csv_next.text_len = csv_next.text_len + 8'd1;
        if (data_byte == CH_COMMA) begin
          if (csv_next.in_token) begin
            t = finish_token(csv_next, accum_next, final_weight_next, final_impedance_next);
            csv_next             = t.cs;
            final_weight_next    = t.fw;
            final_impedance_next = t.fi;
          end
        end else begin
          if (!csv_next.in_token) begin
            csv_next.in_token = 1'b1;
            csv_next.phase    = PH_SPACE;
            csv_next.negative = 1'b0;
            accum_next        = '0;
          end
          if (csv_next.phase == PH_SPACE &&
              (data_byte == CH_SPACE || (data_byte >= CH_TAB && data_byte <= CH_CR))) begin
            // skip leading whitespace
          end else if (csv_next.phase == PH_SPACE &&
                       (data_byte == CH_PLUS || data_byte == CH_MINUS)) begin
            csv_next.negative = (data_byte == CH_MINUS);
            csv_next.phase    = PH_DIGITS;
          end else if (csv_next.phase != PH_DONE &&
                       data_byte >= CH_ZERO && data_byte <= CH_NINE) begin
            wide = 21'(accum_next) * 21'd10 + 21'(data_byte - CH_ZERO);
            accum_next = (wide > 21'(ACC_MAX)) ? ACC_MAX : wide[16:0];
            csv_next.phase = PH_DIGITS;
          end else begin
            csv_next.phase = PH_DONE;
          end
        end
      end
    end
  end

  // Close an open token at the frame end
  always_comb begin
    if (csv_next.in_token) begin
      end_tok = finish_token(csv_next, accum_next, final_weight_next, final_impedance_next);
    end else begin
      end_tok.cs = csv_next;
      end_tok.fw = final_weight_next;
      end_tok.fi = final_impedance_next;
    end
  end

  assign info.live_end = take && last_byte && frame_type_next == TYPE_LIVE &&
                         byte_index >= LIVE_LAST;
  assign info.final_end = take && last_byte && byte_index >= FIN_LAST &&
                          (frame_type_next == TYPE_FIN_A || frame_type_next == TYPE_FIN_B ||
                           frame_type_next == TYPE_FIN_C);
  assign info.raw_weight      = raw_weight_next;
  assign info.final_weight    = end_tok.fw;
  assign info.final_impedance = end_tok.fi;

  // Hold frame state, advance on each byte word
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index      <= '0;
      frame_type      <= '0;
      raw_weight      <= '0;
      csv_parse_state <= '0;
      number_accum    <= '0;
      final_weight    <= swfs_pkg::WEIGHT_ABSENT;
      final_impedance <= '0;
    end else if (take) begin
      if (last_byte) begin
        byte_index <= '0;
      end else if (byte_index != IDX_MAX) begin
        byte_index <= byte_index + 8'd1;
      end
      frame_type      <= frame_type_next;
      raw_weight      <= raw_weight_next;
      csv_parse_state <= csv_next;
      number_accum    <= accum_next;
      final_weight    <= final_weight_next;
      final_impedance <= final_impedance_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/swfs_stabilizer.sv =====
// Stability tracker, load timers and configuration registers.
`timescale 1ns / 1ps
`default_nettype none
module swfs_stabilizer (
  input  logic                  clk,
  input  logic                  rst,
  input  swfs_pkg::cfg_t        cfg,
  input  logic                  tick,
  input  swfs_pkg::frame_info_t info,
  output logic                  res_valid,
  output swfs_pkg::result_t     res
);

  localparam logic [17:0] SINCE_MAX  = 18'h3FFFF;
  localparam logic [3:0]  STEADY_MAX = 4'd15;

  logic [15:0] min_load;
  logic [15:0] tolerance;
  logic [3:0]  steady_frames;
  logic [17:0] loaded_window;
  logic [17:0] rearm_delay;
  logic [17:0] idle_limit;

  logic [15:0] prev_weight,        prev_weight_next;
  logic        have_prev,          have_prev_next;
  logic [3:0]  steady_count,       steady_count_next;
  logic        locked,             locked_next;
  logic        recorded_this_load, recorded_next;
  logic [17:0] since_load_ms,      since_next;
  logic        was_loaded,         was_loaded_next;
  logic        idle_sent,          idle_sent_next;

  // Decide the state update and result for one word
  always_comb begin
    logic [17:0] since_inc;
    logic        loaded;
    logic [15:0] diff;
    prev_weight_next  = prev_weight;
    have_prev_next    = have_prev;
    steady_count_next = steady_count;
    locked_next       = locked;
    recorded_next     = recorded_this_load;
    since_next        = since_load_ms;
    was_loaded_next   = was_loaded;
    idle_sent_next    = idle_sent;
    res_valid         = 1'b0;
    res               = '0;
    since_inc         = (since_load_ms == SINCE_MAX) ? since_load_ms : since_load_ms + 18'd1;
    loaded            = since_inc < loaded_window;
    diff              = (info.raw_weight > prev_weight) ? info.raw_weight - prev_weight
                                                        : prev_weight - info.raw_weight;
    if (tick) begin
      since_next = since_inc;
      // Report loaded state changes
      if (loaded != was_loaded) begin
        was_loaded_next = loaded;
        res_valid       = 1'b1;
        res.kind        = loaded ? swfs_pkg::KIND_READING : swfs_pkg::KIND_READY;
      end
      // Re-arm after a recorded stand has been left long enough
      if (!loaded && recorded_this_load && since_inc > rearm_delay) begin
        prev_weight_next  = '0;
        have_prev_next    = 1'b0;
        steady_count_next = '0;
        locked_next       = 1'b0;
        recorded_next     = 1'b0;
      end
      // Idle release, once per load, deferred behind a status change
      if (!res_valid && !idle_sent && since_inc > idle_limit) begin
        idle_sent_next = 1'b1;
        res_valid      = 1'b1;
        res.kind       = swfs_pkg::KIND_IDLE;
      end
    end else if (info.live_end) begin
      if (info.raw_weight < min_load) begin
        prev_weight_next  = '0;
        have_prev_next    = 1'b0;
        steady_count_next = '0;
        locked_next       = 1'b0;
        recorded_next     = 1'b0;
      end else begin
        since_next     = '0;
        idle_sent_next = 1'b0;
        if (!locked) begin
          if (have_prev && prev_weight != 16'd0 && diff <= tolerance) begin
            if (steady_count != STEADY_MAX) begin
              steady_count_next = steady_count + 4'd1;
            end
          end else begin
            steady_count_next = '0;
          end
          prev_weight_next = info.raw_weight;
          have_prev_next   = 1'b1;
          if (steady_count_next >= steady_frames) begin
            locked_next = 1'b1;
            if (!recorded_this_load) begin
              recorded_next = 1'b1;
              res.recorded  = 1'b1;
            end
          end
        end
        res_valid          = 1'b1;
        res.kind           = swfs_pkg::KIND_LIVE;
        res.weight_centikg = info.raw_weight;
      end
    end else if (info.final_end) begin
      if (info.final_weight != swfs_pkg::WEIGHT_ABSENT) begin
        since_next     = '0;
        idle_sent_next = 1'b0;
        if (!recorded_this_load) begin
          recorded_next      = 1'b1;
          res_valid          = 1'b1;
          res.kind           = swfs_pkg::KIND_FINAL;
          res.weight_centikg = info.final_weight[15:0];
          res.recorded       = 1'b1;
          res.impedance      = info.final_impedance;
        end
      end
    end
  end

  // Hold configuration, take writes by index
  always_ff @(posedge clk) begin
    if (rst) begin
      min_load      <= swfs_pkg::MIN_LOAD_RESET;
      tolerance     <= swfs_pkg::TOLERANCE_RESET;
      steady_frames <= swfs_pkg::STEADY_FRAMES_RESET;
      loaded_window <= swfs_pkg::LOADED_WINDOW_RESET;
      rearm_delay   <= swfs_pkg::REARM_DELAY_RESET;
      idle_limit    <= swfs_pkg::IDLE_LIMIT_RESET;
    end else if (cfg.we) begin
      unique case (cfg.index)
        swfs_pkg::CFG_MIN_LOAD:      min_load      <= cfg.data[15:0];
        swfs_pkg::CFG_TOLERANCE:     tolerance     <= cfg.data[15:0];
        swfs_pkg::CFG_STEADY_FRAMES: steady_frames <= cfg.data[3:0];
        swfs_pkg::CFG_LOADED_WINDOW: loaded_window <= cfg.data;
        swfs_pkg::CFG_REARM_DELAY:   rearm_delay   <= cfg.data;
        swfs_pkg::CFG_IDLE_LIMIT:    idle_limit    <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Advance stability and timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_weight        <= '0;
      have_prev          <= 1'b0;
      steady_count       <= '0;
      locked             <= 1'b0;
      recorded_this_load <= 1'b0;
      since_load_ms      <= '0;
      was_loaded         <= 1'b0;
      idle_sent          <= 1'b0;
    end else begin
      prev_weight        <= prev_weight_next;
      have_prev          <= have_prev_next;
      steady_count       <= steady_count_next;
      locked             <= locked_next;
      recorded_this_load <= recorded_next;
      since_load_ms      <= since_next;
      was_loaded         <= was_loaded_next;
      idle_sent          <= idle_sent_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/swfs_out_buffer.sv =====
// Result register with one skid entry.
`timescale 1ns / 1ps
`default_nettype none
module swfs_out_buffer (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  swfs_pkg::result_t push_data,
  output logic              space,
  output logic              result_valid,
  input  logic              result_ready,
  output swfs_pkg::result_t result
);

  logic              skid_valid;
  swfs_pkg::result_t skid_data;

  assign space = !skid_valid;

  // Refill the output register, park a word in the skid entry on a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || result_ready) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (!result_valid || result_ready) begin
      result <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule
`default_nettype wire
